@@ hw/rtl/mlp_2_2_1_sigmoid_forward_defines.svh @@
// assertion helpers for the top-level rtl
`ifndef MLP_2_2_1_SIGMOID_FORWARD_DEFINES_SVH
`define MLP_2_2_1_SIGMOID_FORWARD_DEFINES_SVH

// checked only while out of reset
`define MLP221_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define MLP221_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/mlp221_pkg.sv @@
package mlp221_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned NumWeights = 6;
  localparam int unsigned CfgIdxW = 3;

  // pipeline depth of one lane of each kind
  localparam int unsigned SigStages = 3;
  localparam int unsigned NeuStages = 2;

  // sigmoid lookup: q8.8 argument clamped to +-8.0, 12-bit interpolation fraction
  localparam int unsigned FracW = 12;
  localparam int unsigned OffsW = 13;
  localparam logic signed [DataW-1:0] SigClamp = 16'sd2048;

  typedef enum logic [CfgIdxW-1:0] {
    WgtHidAFromA = 3'd0,
    WgtHidAFromB = 3'd1,
    WgtHidBFromA = 3'd2,
    WgtHidBFromB = 3'd3,
    WgtOutFromHidA = 3'd4,
    WgtOutFromHidB = 3'd5
  } weight_idx_e;

  localparam logic [DataW-1:0] WeightReset [NumWeights] = '{
    16'd512, 16'd1024, 16'd1536, 16'd1280, 16'd768, 16'd512
  };

  // shift-subtract division, only used while building constant tables
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // raw sigmoid sample i of a table with nm1+1 points over -8..+8, q0.16
  function automatic logic [DataW-1:0] sig_entry(longint unsigned nm1, longint unsigned i);
    longint unsigned twice;
    longint unsigned m;
    longint unsigned d;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned ev;
    longint unsigned num;
    longint unsigned den;
    longint unsigned s;
    longint unsigned n;
    logic pos;
    twice = 2 * i;
    pos = twice > nm1;
    m = pos ? twice - nm1 : nm1 - twice;
    d = 2 * nm1;
    term = 64'd1 << 40;
    sum = term;
    // e^(|x|/16) as a q40 series
    for (n = 1; n < 40; n++) begin
      if (term != 0) begin
        term = udiv64(term * m, d * n);
        sum = sum + term;
      end
    end
    ev = (sum + (64'd1 << 15)) >> 16;
    for (int k = 0; k < 4; k++) begin
      ev = (ev * ev + (64'd1 << 23)) >> 24;
    end
    num = pos ? ev : (64'd1 << 24);
    den = ev + (64'd1 << 24);
    s = udiv64(num * 65536 + (den >> 1), den);
    if (s > 65535) begin
      s = 65535;
    end
    return s[DataW-1:0];
  endfunction

endpackage

@@ hw/rtl/mlp221_sigmoid.sv @@
module mlp221_sigmoid #(
  parameter int unsigned TableSize = 256
) (
  input  logic                                  clk_i,
  input  logic [mlp221_pkg::SigStages-1:0]      en_i,
  input  logic signed [mlp221_pkg::DataW-1:0]   r_i,
  output logic [mlp221_pkg::DataW-1:0]          y_o
);

  localparam int unsigned Nm1 = TableSize - 1;
  localparam int unsigned IdxW = $clog2(TableSize);
  localparam int unsigned ProdW = mlp221_pkg::OffsW + IdxW;
  localparam int unsigned DataW = mlp221_pkg::DataW;
  localparam int unsigned FracW = mlp221_pkg::FracW;
  localparam int unsigned MulW = DataW + FracW;

  typedef logic [DataW-1:0] sig_tbl_t [TableSize];

  function automatic sig_tbl_t build_tbl();
    sig_tbl_t t;
    logic [DataW-1:0] s;
    for (int i = 0; i < TableSize; i++) begin
      s = mlp221_pkg::sig_entry(64'(Nm1), 64'(i));
      // keep the table nondecreasing
      if (i > 0) begin
        if (s < t[i-1]) begin
          s = t[i-1];
        end
      end
      t[i] = s;
    end
    return t;
  endfunction

  localparam sig_tbl_t SigTbl = build_tbl();

  // stage 1: clamp and scale to table position
  logic signed [DataW-1:0] r_clamp;
  logic signed [DataW-1:0] r_off;
  logic [ProdW-1:0]        pos;
  logic [IdxW-1:0]         idx_d, idx_q;
  logic [FracW-1:0]        frac_d, frac_q;
  logic                    top_d, top_q;

  always_comb begin
    if (r_i < -mlp221_pkg::SigClamp) begin
      r_clamp = -mlp221_pkg::SigClamp;
    end else if (r_i > mlp221_pkg::SigClamp) begin
      r_clamp = mlp221_pkg::SigClamp;
    end else begin
      r_clamp = r_i;
    end
    r_off = r_clamp + mlp221_pkg::SigClamp;
    pos = ProdW'(r_off[mlp221_pkg::OffsW-1:0]) * ProdW'(Nm1);
    idx_d = pos[FracW +: IdxW];
    frac_d = pos[FracW-1:0];
    top_d = (idx_d == IdxW'(Nm1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      idx_q <= idx_d;
      frac_q <= frac_d;
      top_q <= top_d;
    end
  end

  // stage 2: two table reads, at the last point both read the same entry
  logic [IdxW-1:0]  idx_nx;
  logic [DataW-1:0] lo_d, lo_q;
  logic [DataW-1:0] diff_d, diff_q;
  logic [FracW-1:0] frac2_q;

  always_comb begin
    idx_nx = top_q ? idx_q : IdxW'(idx_q + 1'b1);
    lo_d = SigTbl[idx_q];
    diff_d = SigTbl[idx_nx] - lo_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      lo_q <= lo_d;
      diff_q <= diff_d;
      frac2_q <= frac_q;
    end
  end

  // stage 3: interpolate with round half up
  logic [MulW-1:0]  mul;
  logic [MulW:0]    rnd;
  logic [DataW-1:0] y_d, y_q;

  always_comb begin
    mul = MulW'(diff_q) * MulW'(frac2_q);
    rnd = {1'b0, mul} + (MulW+1)'(1 << (FracW - 1));
    y_d = lo_q + rnd[FracW +: DataW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

@@ hw/rtl/mlp221_neuron.sv @@
module mlp221_neuron (
  input  logic                                  clk_i,
  input  logic [mlp221_pkg::NeuStages-1:0]      en_i,
  input  logic signed [mlp221_pkg::DataW-1:0]   w0_i,
  input  logic signed [mlp221_pkg::DataW-1:0]   w1_i,
  input  logic [mlp221_pkg::DataW-1:0]          a0_i,
  input  logic [mlp221_pkg::DataW-1:0]          a1_i,
  output logic signed [mlp221_pkg::DataW-1:0]   sum_o
);

  localparam int unsigned DataW = mlp221_pkg::DataW;
  localparam int unsigned ProdW = 2 * DataW + 1;
  localparam int unsigned AccW = ProdW + 2;

  // stage 1: q8.8 weight times q0.16 activation
  logic signed [ProdW-1:0] p0_d, p0_q;
  logic signed [ProdW-1:0] p1_d, p1_q;

  always_comb begin
    p0_d = ProdW'(w0_i) * ProdW'($signed({1'b0, a0_i}));
    p1_d = ProdW'(w1_i) * ProdW'($signed({1'b0, a1_i}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
    end
  end

  // stage 2: q8.24 sum back to q8.8, round half up, saturate
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  q;
  logic signed [DataW-1:0] sum_d, sum_q;

  always_comb begin
    acc = AccW'(p0_q) + AccW'(p1_q) + AccW'(32768);
    q = acc >>> DataW;
    if (q > AccW'(32767)) begin
      sum_d = 16'sh7fff;
    end else if (q < -AccW'(32768)) begin
      sum_d = 16'sh8000;
    end else begin
      sum_d = q[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ hw/rtl/mlp_2_2_1_sigmoid_forward.sv @@
// Forward pass of a 2-2-1 sigmoid network. One input pair (two signed q8.8
// values) is taken per cycle unless stalled, and each beat yields one result
// beat carrying the two input activations, the two hidden activations and
// the network output, all unsigned q0.16. Stages: two input sigmoid lanes
// (3 stages), two hidden neuron lanes (2 stages: multiply, then sum with
// rounding and saturation), two hidden sigmoid lanes (3 stages), the output
// neuron merging both hidden lanes (2 stages) and the output sigmoid (3
// stages). Each sigmoid lane reads the interpolation table twice per beat;
// the table is constant logic built at elaboration from SIGMOID_TABLE_SIZE.
// Bubbles close up under output stall, so in_stall_o rises only when all 13
// stages hold data. The six weights reset to 2, 4, 6, 5, 3 and 2; the user
// must write them through cfg_we_i only while the block is idle, which the
// block does not enforce. Indexes past the last weight are ignored.
`include "mlp_2_2_1_sigmoid_forward_defines.svh"

module mlp_2_2_1_sigmoid_forward #(
  parameter int unsigned SIGMOID_TABLE_SIZE = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [mlp221_pkg::DataW-1:0]   input_a_i,
  input  logic signed [mlp221_pkg::DataW-1:0]   input_b_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [mlp221_pkg::DataW-1:0]          act_input_a_o,
  output logic [mlp221_pkg::DataW-1:0]          act_input_b_o,
  output logic [mlp221_pkg::DataW-1:0]          act_hidden_a_o,
  output logic [mlp221_pkg::DataW-1:0]          act_hidden_b_o,
  output logic [mlp221_pkg::DataW-1:0]          net_out_o,
  input  logic                                  cfg_we_i,
  input  logic [mlp221_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mlp221_pkg::DataW-1:0]          cfg_data_i
);

  localparam int unsigned DataW = mlp221_pkg::DataW;
  localparam int unsigned SigSt = mlp221_pkg::SigStages;
  localparam int unsigned NeuSt = mlp221_pkg::NeuStages;
  localparam int unsigned HidBase = SigSt;
  localparam int unsigned HidSigBase = SigSt + NeuSt;
  localparam int unsigned OutBase = 2 * SigSt + NeuSt;
  localparam int unsigned OutSigBase = 2 * SigSt + 2 * NeuSt;
  localparam int unsigned Depth = 3 * SigSt + 2 * NeuSt;
  localparam int unsigned InDly = Depth - SigSt;
  localparam int unsigned HidDly = Depth - OutBase;

  // weight registers
  logic signed [DataW-1:0] weight_d [mlp221_pkg::NumWeights];
  logic signed [DataW-1:0] weight_q [mlp221_pkg::NumWeights];
  mlp221_pkg::weight_idx_e cfg_sel;

  assign cfg_sel = mlp221_pkg::weight_idx_e'(cfg_idx_i);

  always_comb begin
    weight_d = weight_q;
    if (cfg_we_i) begin
      unique case (cfg_sel) inside
        mlp221_pkg::WgtHidAFromA, mlp221_pkg::WgtHidAFromB,
        mlp221_pkg::WgtHidBFromA, mlp221_pkg::WgtHidBFromB,
        mlp221_pkg::WgtOutFromHidA, mlp221_pkg::WgtOutFromHidB: begin
          weight_d[cfg_idx_i] = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mlp221_pkg::NumWeights; i++) begin
        weight_q[i] <= mlp221_pkg::WeightReset[i];
      end
    end else begin
      weight_q <= weight_d;
    end
  end

  // stage valids; a stage loads when it is empty or its successor moves on
  logic [Depth-1:0] valid_d, valid_q;
  logic [Depth:0]   ready;
  logic [Depth-1:0] en;

  assign ready[Depth] = !out_stall_i;

  for (genvar k = 0; k < Depth; k++) begin : g_ctrl
    assign ready[k] = !valid_q[k] || ready[k+1];
    if (k == 0) begin : g_first
      assign valid_d[k] = ready[k] ? in_valid_i : valid_q[k];
    end else begin : g_rest
      assign valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  assign en = ready[Depth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o = !ready[0];
  assign out_valid_o = valid_q[Depth-1];

  // input lanes
  logic [DataW-1:0] act_in_a, act_in_b;

  mlp221_sigmoid #(.TableSize(SIGMOID_TABLE_SIZE)) u_sig_in_a (
    .clk_i (clk_i),
    .en_i  (en[0 +: SigSt]),
    .r_i   (input_a_i),
    .y_o   (act_in_a)
  );

  mlp221_sigmoid #(.TableSize(SIGMOID_TABLE_SIZE)) u_sig_in_b (
    .clk_i (clk_i),
    .en_i  (en[0 +: SigSt]),
    .r_i   (input_b_i),
    .y_o   (act_in_b)
  );

  // hidden lanes
  logic signed [DataW-1:0] hid_sum_a, hid_sum_b;
  logic [DataW-1:0]        act_hid_a, act_hid_b;

  mlp221_neuron u_neu_hid_a (
    .clk_i (clk_i),
    .en_i  (en[HidBase +: NeuSt]),
    .w0_i  (weight_q[mlp221_pkg::WgtHidAFromA]),
    .w1_i  (weight_q[mlp221_pkg::WgtHidAFromB]),
    .a0_i  (act_in_a),
    .a1_i  (act_in_b),
    .sum_o (hid_sum_a)
  );

  mlp221_neuron u_neu_hid_b (
    .clk_i (clk_i),
    .en_i  (en[HidBase +: NeuSt]),
    .w0_i  (weight_q[mlp221_pkg::WgtHidBFromA]),
    .w1_i  (weight_q[mlp221_pkg::WgtHidBFromB]),
    .a0_i  (act_in_a),
    .a1_i  (act_in_b),
    .sum_o (hid_sum_b)
  );

  mlp221_sigmoid #(.TableSize(SIGMOID_TABLE_SIZE)) u_sig_hid_a (
    .clk_i (clk_i),
    .en_i  (en[HidSigBase +: SigSt]),
    .r_i   (hid_sum_a),
    .y_o   (act_hid_a)
  );

  mlp221_sigmoid #(.TableSize(SIGMOID_TABLE_SIZE)) u_sig_hid_b (
    .clk_i (clk_i),
    .en_i  (en[HidSigBase +: SigSt]),
    .r_i   (hid_sum_b),
    .y_o   (act_hid_b)
  );

  // output neuron merges the hidden lanes
  logic signed [DataW-1:0] out_sum;
  logic [DataW-1:0]        act_out;

  mlp221_neuron u_neu_out (
    .clk_i (clk_i),
    .en_i  (en[OutBase +: NeuSt]),
    .w0_i  (weight_q[mlp221_pkg::WgtOutFromHidA]),
    .w1_i  (weight_q[mlp221_pkg::WgtOutFromHidB]),
    .a0_i  (act_hid_a),
    .a1_i  (act_hid_b),
    .sum_o (out_sum)
  );

  mlp221_sigmoid #(.TableSize(SIGMOID_TABLE_SIZE)) u_sig_out (
    .clk_i (clk_i),
    .en_i  (en[OutSigBase +: SigSt]),
    .r_i   (out_sum),
    .y_o   (act_out)
  );

  // side activations ride along with their beat to the last stage
  logic [DataW-1:0] in_a_dly_q  [InDly];
  logic [DataW-1:0] in_b_dly_q  [InDly];
  logic [DataW-1:0] hid_a_dly_q [HidDly];
  logic [DataW-1:0] hid_b_dly_q [HidDly];

  for (genvar j = 0; j < InDly; j++) begin : g_in_dly
    if (j == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en[SigSt + j]) begin
          in_a_dly_q[j] <= act_in_a;
          in_b_dly_q[j] <= act_in_b;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (en[SigSt + j]) begin
          in_a_dly_q[j] <= in_a_dly_q[j-1];
          in_b_dly_q[j] <= in_b_dly_q[j-1];
        end
      end
    end
  end

  for (genvar j = 0; j < HidDly; j++) begin : g_hid_dly
    if (j == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en[OutBase + j]) begin
          hid_a_dly_q[j] <= act_hid_a;
          hid_b_dly_q[j] <= act_hid_b;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (en[OutBase + j]) begin
          hid_a_dly_q[j] <= hid_a_dly_q[j-1];
          hid_b_dly_q[j] <= hid_b_dly_q[j-1];
        end
      end
    end
  end

  assign act_input_a_o = in_a_dly_q[InDly-1];
  assign act_input_b_o = in_b_dly_q[InDly-1];
  assign act_hidden_a_o = hid_a_dly_q[HidDly-1];
  assign act_hidden_b_o = hid_b_dly_q[HidDly-1];
  assign net_out_o = act_out;

  logic in_acc, out_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // the pipe pushes back only when every stage is occupied
  `MLP221_ASSERT_ALWAYS(a_stall_only_full, in_stall_o |-> (&valid_q), "input stalled with a free stage")
  // beats in flight change only by what enters and leaves
  `MLP221_ASSERT(a_beat_count, $past(rst_ni) |-> ($countones(valid_q) == $past($countones(valid_q)) + $past(in_acc) - $past(out_acc)), "beat count out of step")

endmodule

@@ dv/tb_mlp_2_2_1_sigmoid_forward.sv @@
module tb_mlp_2_2_1_sigmoid_forward;

  localparam int unsigned DataW = mlp221_pkg::DataW;
  localparam int unsigned CfgIdxW = mlp221_pkg::CfgIdxW;
  localparam int unsigned NumWeights = mlp221_pkg::NumWeights;
  localparam int unsigned FracW = mlp221_pkg::FracW;
  localparam int unsigned SigN = 256;
  localparam int unsigned PipeDepth = 3 * mlp221_pkg::SigStages + 2 * mlp221_pkg::NeuStages;
  localparam int unsigned StuckLimit = 1000;
  localparam int unsigned NumPhases = 10;
  localparam int unsigned PhaseBeats = 78;
  // indexes past the last weight, writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  typedef struct packed {
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } input_pair_t;

  typedef struct packed {
    logic [DataW-1:0] act_in_a;
    logic [DataW-1:0] act_in_b;
    logic [DataW-1:0] act_hid_a;
    logic [DataW-1:0] act_hid_b;
    logic [DataW-1:0] net;
  } net_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DataW-1:0] input_a_i = '0;
  logic signed [DataW-1:0] input_b_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [DataW-1:0] act_input_a_o;
  logic [DataW-1:0] act_input_b_o;
  logic [DataW-1:0] act_hidden_a_o;
  logic [DataW-1:0] act_hidden_b_o;
  logic [DataW-1:0] net_out_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;

  longint unsigned sig_lut [SigN];
  logic [DataW-1:0] weights_q88 [NumWeights];
  input_pair_t pairs_to_send [$];
  net_result_t activations_due [$];
  int unsigned idle_odds = 0;
  int unsigned send_gap = 0;
  int unsigned stall_gap = 0;
  int unsigned stuck_cycles = 0;
  int unsigned mismatches = 0;

  mlp_2_2_1_sigmoid_forward #(
    .SIGMOID_TABLE_SIZE(SigN)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .input_a_i,
    .input_b_i,
    .out_valid_o,
    .out_stall_i,
    .act_input_a_o,
    .act_input_b_o,
    .act_hidden_a_o,
    .act_hidden_b_o,
    .net_out_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // samples at -8..+8, e^|x| as the 16th power of a series for e^(|x|/16)
  function automatic void build_sig_lut();
    longint unsigned nm1, twice, m, term, total, ev, num, den, s, n;
    bit pos;
    nm1 = SigN - 1;
    for (int i = 0; i < SigN; i++) begin
      twice = 2 * i;
      pos = twice > nm1;
      m = pos ? twice - nm1 : nm1 - twice;
      term = 64'd1 << 40;
      total = term;
      for (n = 1; n < 40 && term != 0; n++) begin
        term = (term * m) / (2 * nm1 * n);
        total += term;
      end
      ev = (total + (64'd1 << 15)) >> 16;
      repeat (4) ev = (ev * ev + (64'd1 << 23)) >> 24;
      num = pos ? ev : (64'd1 << 24);
      den = ev + (64'd1 << 24);
      s = (num * 65536 + den / 2) / den;
      if (s > 65535) s = 65535;
      // keep the table monotonic
      if (i > 0 && s < sig_lut[i-1]) s = sig_lut[i-1];
      sig_lut[i] = s;
    end
  endfunction

  function automatic logic [DataW-1:0] sig_lookup(int arg);
    longint unsigned p, idx, frac, lo, hi;
    if (arg < -2048) arg = -2048;
    if (arg > 2048) arg = 2048;
    p = longint'(arg + 2048) * (SigN - 1);
    idx = p >> FracW;
    frac = p & 4095;
    if (idx >= SigN - 1) return DataW'(sig_lut[SigN-1]);
    lo = sig_lut[idx];
    hi = sig_lut[idx+1];
    return DataW'(lo + (((hi - lo) * frac + 2048) >> FracW));
  endfunction

  // q8.8 weight times q0.16 activation, back to q8.8 with round half up
  function automatic int weighted_q88(logic [DataW-1:0] w0, logic [DataW-1:0] a0,
                                      logic [DataW-1:0] w1, logic [DataW-1:0] a1);
    longint acc;
    longint q;
    acc = longint'($signed(w0)) * longint'(a0) + longint'($signed(w1)) * longint'(a1);
    q = (acc + 32768) >>> 16;
    if (q < -32768) q = -32768;
    if (q > 32767) q = 32767;
    return int'(q);
  endfunction

  function automatic net_result_t net_forward(logic [DataW-1:0] in_a, logic [DataW-1:0] in_b);
    net_result_t r;
    r.act_in_a = sig_lookup($signed(in_a));
    r.act_in_b = sig_lookup($signed(in_b));
    r.act_hid_a = sig_lookup(weighted_q88(
        weights_q88[mlp221_pkg::WgtHidAFromA], r.act_in_a,
        weights_q88[mlp221_pkg::WgtHidAFromB], r.act_in_b));
    r.act_hid_b = sig_lookup(weighted_q88(
        weights_q88[mlp221_pkg::WgtHidBFromA], r.act_in_a,
        weights_q88[mlp221_pkg::WgtHidBFromB], r.act_in_b));
    r.net = sig_lookup(weighted_q88(
        weights_q88[mlp221_pkg::WgtOutFromHidA], r.act_hid_a,
        weights_q88[mlp221_pkg::WgtOutFromHidB], r.act_hid_b));
    return r;
  endfunction

  function automatic logic [DataW-1:0] rand_input();
    case ($urandom_range(0, 9))
      0, 1: return DataW'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'hF800;
          default: return 16'h0800;
        endcase
      end
      // mostly inside the table range where interpolation matters
      default: return DataW'($urandom_range(0, 4200) - 2100);
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return DataW'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return DataW'($urandom_range(0, 4096) - 2048);
    endcase
  endfunction

  task automatic queue_pair(logic [DataW-1:0] a, logic [DataW-1:0] b);
    input_pair_t p;
    p.a = a;
    p.b = b;
    pairs_to_send.insert(pairs_to_send.size(), p);
  endtask

  task automatic write_weight(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    if (idx < NumWeights) weights_q88[idx] = value;
  endtask

  task automatic cfg_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pairs_to_send.size() != 0 || activations_due.size() != 0);
  endtask

  task automatic check_field(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        activations_due.insert(activations_due.size(), net_forward(input_a_i, input_b_i));
        pairs_to_send.delete(0);
      end
      // a stalled beat is held as it is
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pairs_to_send.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          send_gap = $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          input_a_i <= pairs_to_send[0].a;
          input_b_i <= pairs_to_send[0].b;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    net_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (activations_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none got %h %h %h %h %h",
                   $time, act_input_a_o, act_input_b_o, act_hidden_a_o, act_hidden_b_o,
                   net_out_o);
          mismatches++;
        end else begin
          want = activations_due.pop_front();
          check_field("act_input_a", want.act_in_a, act_input_a_o);
          check_field("act_input_b", want.act_in_b, act_input_b_o);
          check_field("act_hidden_a", want.act_hid_a, act_hidden_a_o);
          check_field("act_hidden_b", want.act_hid_b, act_hidden_b_o);
          check_field("net_out", want.net, net_out_o);
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_stall_i <= 1'b1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_gap = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // only counts while work is outstanding
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (pairs_to_send.size() == 0 && activations_due.size() == 0)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [DataW-1:0] val;
    build_sig_lut();
    foreach (weights_q88[i]) weights_q88[i] = mlp221_pkg::WeightReset[i];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // field extremes, table edges and interpolation corners at reset weights
    idle_odds = 4;
    queue_pair(16'h0000, 16'h0000);
    queue_pair(16'h8000, 16'h8000);
    queue_pair(16'h7FFF, 16'h7FFF);
    queue_pair(16'h8000, 16'h7FFF);
    queue_pair(16'h7FFF, 16'h8000);
    queue_pair(16'hF800, 16'h0800);
    queue_pair(16'hF7FF, 16'h0801);
    queue_pair(16'hF801, 16'h07FF);
    queue_pair(16'h0001, 16'hFFFF);
    queue_pair(16'hFFFF, 16'h0001);
    queue_pair(16'h5555, 16'hAAAA);
    queue_pair(16'h0011, 16'hFFEF);
    queue_pair(16'h07F8, 16'hF808);
    queue_pair(16'h0064, 16'hFED4);
    queue_pair(16'hFF00, 16'h0100);
    queue_pair(16'h0400, 16'hFC00);
    wait_drained();

    // writes past the last weight must leave the network unchanged
    write_weight(CfgIdxSpareLo, 16'h8000);
    write_weight(CfgIdxSpareHi, 16'h7FFF);
    cfg_done();
    repeat (10) queue_pair(rand_input(), rand_input());
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      for (int w = 0; w < NumWeights; w++) begin
        case (ph)
          0: val = 16'h7FFF;
          1: val = 16'h8000;
          2: val = '0;
          3: val = w[0] ? 16'h8000 : 16'h7FFF;
          default: val = rand_weight();
        endcase
        write_weight(mlp221_pkg::weight_idx_e'(w), val);
      end
      cfg_done();
      if (ph == NumPhases - 1) idle_odds = 0;
      else idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 10);
      repeat (PhaseBeats) queue_pair(rand_input(), rand_input());
      wait_drained();
    end

    repeat (PipeDepth + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mlp221_pkg.sv
hw/rtl/mlp221_sigmoid.sv
hw/rtl/mlp221_neuron.sv
hw/rtl/mlp_2_2_1_sigmoid_forward.sv
dv/tb_mlp_2_2_1_sigmoid_forward.sv
